FILE: design/overwrite_event_ring_buffer_core_macros.svh
// ----------------------------------------------------------------------------
// overwrite event ring buffer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_EVENT_RING_BUFFER_CORE_MACROS_SVH
`define OVERWRITE_EVENT_RING_BUFFER_CORE_MACROS_SVH

// property that must hold at every edge out of reset
`define OERB_ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never be seen out of reset
`define OERB_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

FILE: design/oerb_pkg.sv
// ----------------------------------------------------------------------------
// oerb_pkg
// types and constants shared by the event ring buffer controller and datapath
// ----------------------------------------------------------------------------
package oerb_pkg;

	localparam int DEFAULT_DEPTH = 128;
	localparam int CODE_W        = 8;
	localparam int TIME_W        = 63;
	localparam int HIST_W        = 7;
	localparam int KEY_W         = 7;
	localparam int COUNT_W       = 8;
	localparam int WORD_W        = CODE_W + TIME_W;

	localparam logic [CODE_W-1:0] CODE_MASK    = 8'h7f;
	localparam logic [CODE_W-1:0] RELEASE_MASK = 8'h80;

	// operation codes
	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_HIST = 2'd2
	} kind_t;

	// request word
	typedef struct packed {
		logic [1:0]        kind;
		logic [CODE_W-1:0] scancode;
		logic [TIME_W-1:0] timestamp;
		logic [HIST_W-1:0] history_index;
	} req_t;

	// response word
	typedef struct packed {
		logic               valid_res;
		logic [CODE_W-1:0]  raw_byte;
		logic [KEY_W-1:0]   key_code;
		logic               pressed;
		logic [TIME_W-1:0]  event_time;
		logic [COUNT_W-1:0] unread_count;
		logic [COUNT_W-1:0] retained_count;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic exec;
		logic load;
	} ctl_cmd_t;

endpackage

FILE: design/oerb_ctrl.sv
// ----------------------------------------------------------------------------
// oerb_ctrl
// sequences one word at a time: accept, memory read, hold response
// ----------------------------------------------------------------------------
module oerb_ctrl import oerb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_HOLD
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (!rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// handshake and datapath commands
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_HOLD);
	assign cmd.exec  = (state_q == ST_IDLE) && req_valid;
	assign cmd.load  = (state_q == ST_FETCH);

endmodule

FILE: design/oerb_dp.sv
// ----------------------------------------------------------------------------
// oerb_dp
// entry memory, ring pointers, counts and the response register
// ----------------------------------------------------------------------------
`include "overwrite_event_ring_buffer_core_macros.svh"

module oerb_dp import oerb_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_cmd_t cmd,
	input  req_t     req,
	output rsp_t     rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int HW = (CW > HIST_W) ? CW : HIST_W;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	logic [AW-1:0] wp_q, rp_q, wp_nxt, rp_nxt, rd_addr, hist_addr, wp_inc, rp_inc;
	logic [CW-1:0] unread_q, retained_q, unread_nxt, retained_nxt;
	logic [CW-1:0] hist_dist, wp_ext;
	logic [HW-1:0] hist_gap;
	logic          full, hist_hit, do_write, valid_nxt, emit_nxt;
	logic          valid_q, emit_q;
	logic [CODE_W-1:0] raw;
	rsp_t          rsp_q, rsp_nxt;

	// pointer wrap and history address
	always_comb begin
		wp_inc    = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
		rp_inc    = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
		full      = (unread_q == CW'(DEPTH));
		hist_hit  = (HW'(req.history_index) < HW'(retained_q));
		hist_gap  = HW'(retained_q) - HW'(req.history_index);
		hist_dist = CW'(hist_gap);
		wp_ext    = CW'(wp_q);
		if (wp_ext >= hist_dist) begin
			hist_addr = AW'(wp_ext - hist_dist);
		end else begin
			hist_addr = AW'(wp_ext + CW'(DEPTH) - hist_dist);
		end
	end

	// next state per operation
	always_comb begin
		wp_nxt       = wp_q;
		rp_nxt       = rp_q;
		unread_nxt   = unread_q;
		retained_nxt = retained_q;
		rd_addr      = rp_q;
		do_write     = 1'b0;
		valid_nxt    = 1'b0;
		emit_nxt     = 1'b0;
		unique case (req.kind)
			KIND_PUSH: begin
				do_write  = 1'b1;
				valid_nxt = 1'b1;
				wp_nxt    = wp_inc;
				if (full) begin
					rp_nxt = rp_inc;
				end else begin
					unread_nxt = unread_q + 1'b1;
				end
				if (retained_q < CW'(DEPTH)) begin
					retained_nxt = retained_q + 1'b1;
				end
			end
			KIND_POP: begin
				if (unread_q != '0) begin
					valid_nxt  = 1'b1;
					emit_nxt   = 1'b1;
					rp_nxt     = rp_inc;
					unread_nxt = unread_q - 1'b1;
				end
			end
			KIND_HIST: begin
				rd_addr = hist_addr;
				if (hist_hit) begin
					valid_nxt = 1'b1;
					emit_nxt  = 1'b1;
				end
			end
			default: begin
				valid_nxt = 1'b0;
			end
		endcase
	end

	// pointers, counts and operation flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			unread_q   <= '0;
			retained_q <= '0;
			valid_q    <= 1'b0;
			emit_q     <= 1'b0;
		end else if (cmd.exec) begin
			wp_q       <= wp_nxt;
			rp_q       <= rp_nxt;
			unread_q   <= unread_nxt;
			retained_q <= retained_nxt;
			valid_q    <= valid_nxt;
			emit_q     <= emit_nxt;
		end
	end

	// entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && do_write) begin
			mem[wp_q] <= {req.scancode, req.timestamp};
		end
		if (cmd.exec) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// response decode
	always_comb begin
		raw                    = emit_q ? rd_data_q[WORD_W-1 -: CODE_W] : '0;
		rsp_nxt.valid_res      = valid_q;
		rsp_nxt.raw_byte       = raw;
		rsp_nxt.key_code       = KEY_W'(raw & CODE_MASK);
		rsp_nxt.pressed        = emit_q && ((raw & RELEASE_MASK) == '0);
		rsp_nxt.event_time     = emit_q ? rd_data_q[TIME_W-1:0] : '0;
		rsp_nxt.unread_count   = COUNT_W'(unread_q);
		rsp_nxt.retained_count = COUNT_W'(retained_q);
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp = rsp_q;

	`OERB_ASSERT_NEVER(a_unread_le_retained, unread_q > retained_q, "unread exceeds retained")
	`OERB_ASSERT_NEVER(a_retained_le_depth, retained_q > CW'(DEPTH), "retained exceeds depth")
	`OERB_ASSERT_HOLDS(a_retained_grows, retained_q >= $past(retained_q), "retained decreased")
	`OERB_ASSERT_HOLDS(a_pop_drains, cmd.exec && req.kind == KIND_POP && unread_q != '0 |=> unread_q == $past(unread_q) - 1'b1, "pop did not drain one entry")

endmodule

FILE: design/overwrite_event_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// overwrite_event_ring_buffer_core
// timestamped scancode ring with overwrite on full, pop and history read
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid / req_stall / req) carries one operation word:
//   push a scancode and timestamp, pop the oldest unread entry, or read a
//   history entry (index 0 is the oldest retained entry).
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one word per
//   request: the decoded entry or zeros, plus the unread and retained counts.
// timing:
//   a request's memory read is registered as it is taken, its response is
//   registered in the fetch state and held in the hold state; one request
//   is in flight at a time: accept, memory read, response hold.
// stall:
//   while rsp_stall is high the response word holds and req_stall stays high.
// reset:
//   arst_n clears pointers and counts; the entry memory is not cleared and
//   only entries already written are ever emitted in a response.
// ----------------------------------------------------------------------------
module overwrite_event_ring_buffer_core import oerb_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t cmd;

	// sequencing
	oerb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// storage and decode
	oerb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

FILE: verif/overwrite_event_ring_buffer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_event_ring_buffer_core_test
// drives push, pop and history requests into the event ring, predicts every
// response word from a behavioral copy of the ring and compares field by field
// ----------------------------------------------------------------------------
module overwrite_event_ring_buffer_core_test;
	import oerb_pkg::*;

	localparam int RING_DEPTH = DEFAULT_DEPTH;
	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	overwrite_event_ring_buffer_core #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	// behavioral copy of the ring
	logic [CODE_W-1:0] code_mem [RING_DEPTH];
	logic [TIME_W-1:0] time_mem [RING_DEPTH];
	int ring_wr = 0;
	int ring_rd = 0;
	int ring_unread = 0;
	int ring_retained = 0;

	rsp_t expected_rsp_q[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		error_count++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// decoded entry as the ring returns it
	function automatic rsp_t entry_word(input int addr);
		rsp_t e;
		logic [CODE_W-1:0] raw;
		e = '0;
		raw = code_mem[addr % RING_DEPTH];
		e.valid_res = 1'b1;
		e.raw_byte = raw;
		e.key_code = KEY_W'(raw & CODE_MASK);
		e.pressed = ((raw & RELEASE_MASK) == '0);
		e.event_time = time_mem[addr % RING_DEPTH];
		return e;
	endfunction

	// advance the ring by one request and return the response it produces
	function automatic rsp_t ring_step(input req_t w);
		rsp_t r;
		r = '0;
		case (w.kind)
			KIND_PUSH: begin
				// full ring drops its oldest unread entry
				if (ring_unread >= RING_DEPTH) begin
					ring_rd = (ring_rd + 1) % RING_DEPTH;
					ring_unread--;
				end
				if (ring_retained < RING_DEPTH)
					ring_retained++;
				code_mem[ring_wr] = w.scancode;
				time_mem[ring_wr] = w.timestamp;
				ring_wr = (ring_wr + 1) % RING_DEPTH;
				ring_unread++;
				r.valid_res = 1'b1;
			end
			KIND_POP: begin
				if (ring_unread != 0) begin
					r = entry_word(ring_rd);
					ring_rd = (ring_rd + 1) % RING_DEPTH;
					ring_unread--;
				end
			end
			KIND_HIST: begin
				if (int'(w.history_index) < ring_retained)
					r = entry_word(ring_wr + RING_DEPTH - ring_retained
						+ int'(w.history_index));
			end
			default: ;
		endcase
		r.unread_count = COUNT_W'(ring_unread);
		r.retained_count = COUNT_W'(ring_retained);
		return r;
	endfunction

	function automatic req_t make_word(input logic [1:0] kind, input logic [CODE_W-1:0] sc,
		input logic [TIME_W-1:0] ts, input logic [HIST_W-1:0] idx);
		req_t w;
		w.kind = kind;
		w.scancode = sc;
		w.timestamp = ts;
		w.history_index = idx;
		return w;
	endfunction

	// random request; history reads mostly aim inside the retained range
	function automatic req_t random_word(input int push_pct, input int pop_pct,
		input int hist_pct);
		req_t w;
		int pick;
		logic [63:0] ts;
		pick = $urandom_range(0, 99);
		ts = {$urandom(), $urandom()};
		w.scancode = CODE_W'($urandom());
		w.timestamp = ts[TIME_W-1:0];
		w.history_index = HIST_W'($urandom());
		if (pick < push_pct)
			w.kind = KIND_PUSH;
		else if (pick < push_pct + pop_pct)
			w.kind = KIND_POP;
		else if (pick < push_pct + pop_pct + hist_pct)
			w.kind = KIND_HIST;
		else
			w.kind = KIND_NOP;
		if (w.kind == KIND_HIST && ring_retained > 0 && $urandom_range(0, 9) < 8)
			w.history_index = HIST_W'($urandom_range(0, ring_retained - 1));
		return w;
	endfunction

	// offer one word, entered and left at a falling edge
	task automatic send_word(input req_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = w;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		expected_rsp_q.push_back(ring_step(w));
		@(negedge clk);
	endtask

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("unexpected response", 64'(rsp), 64'd0);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.valid_res !== want.valid_res)
					report_mismatch("valid_res", 64'(rsp.valid_res), 64'(want.valid_res));
				if (rsp.raw_byte !== want.raw_byte)
					report_mismatch("raw_byte", 64'(rsp.raw_byte), 64'(want.raw_byte));
				if (rsp.key_code !== want.key_code)
					report_mismatch("key_code", 64'(rsp.key_code), 64'(want.key_code));
				if (rsp.pressed !== want.pressed)
					report_mismatch("pressed", 64'(rsp.pressed), 64'(want.pressed));
				if (rsp.event_time !== want.event_time)
					report_mismatch("event_time", 64'(rsp.event_time), 64'(want.event_time));
				if (rsp.unread_count !== want.unread_count)
					report_mismatch("unread_count", 64'(rsp.unread_count),
						64'(want.unread_count));
				if (rsp.retained_count !== want.retained_count)
					report_mismatch("retained_count", 64'(rsp.retained_count),
						64'(want.retained_count));
			end
		end
	end

	// receiver stall, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall = 1'b1;
			hold_left--;
		end else begin
			rsp_stall = ($urandom_range(0, 99) < stall_pct);
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// pops, history reads and unused kind on an empty ring
	task automatic test_empty_ring();
		send_word(make_word(KIND_POP, 8'h00, '0, 7'd0));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd0));
		send_word(make_word(KIND_HIST, 8'hff, TIME_MAX, 7'd127));
		send_word(make_word(KIND_NOP, 8'h5a, TIME_MAX, 7'd3));
	endtask

	// field extremes, press and release decode
	task automatic test_field_extremes();
		send_word(make_word(KIND_PUSH, 8'h00, '0, 7'd0));
		send_word(make_word(KIND_PUSH, 8'hff, TIME_MAX, 7'd127));
		send_word(make_word(KIND_PUSH, 8'h7f, {32'h5555_5555, 31'h5555_5555}, 7'd0));
		send_word(make_word(KIND_PUSH, 8'h80, {32'haaaa_aaaa, 31'h2aaa_aaaa}, 7'd0));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd0));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd3));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd4));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd127));
	endtask

	// pops drain the ring, history still shows popped entries
	task automatic test_history_after_pop();
		repeat (4)
			send_word(make_word(KIND_POP, 8'hff, TIME_MAX, 7'd127));
		send_word(make_word(KIND_POP, 8'h00, '0, 7'd0));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd0));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd2));
		send_word(make_word(KIND_NOP, 8'h00, '0, 7'd0));
	endtask

	// fill past depth so pushes drop unread entries, then read back
	task automatic test_overflow();
		repeat (140)
			send_word(random_word(100, 0, 0));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd0));
		send_word(make_word(KIND_HIST, 8'h00, '0, 7'd127));
		repeat (18)
			send_word(random_word(0, 0, 100));
		repeat (10)
			send_word(random_word(0, 100, 0));
	endtask

	task automatic run_phase(input int count, input int idle_pct, input int stall_rate);
		send_idle_pct = idle_pct;
		stall_pct = stall_rate;
		repeat (count)
			send_word(random_word(45, 30, 20));
	endtask

	// mixed traffic under each idling pattern
	task automatic test_random_traffic();
		run_phase(80, 66, 0);
		run_phase(80, 0, 66);
		run_phase(80, 28, 28);
		run_phase(30, 0, 0);
	endtask

	// receiver holds off long while requests keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		@(posedge clk);
		hold_left = HOLD_OFF_CYCLES;
		@(negedge clk);
		repeat (20)
			send_word(random_word(50, 25, 20));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_ring();
		test_field_extremes();
		test_history_after_pop();
		test_overflow();
		test_random_traffic();
		test_backpressure();
		req_valid = 1'b0;

		// wait for every outstanding response, then let the ring settle
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
